>>> rtl/core/hrht_pkg.sv
package hrht_pkg;

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_URL,
      PH_PROTO,
      PH_VERSION,
      PH_NAME,
      PH_LEAD,
      PH_VALUE,
      PH_DONE
   } phase_type;

   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_METHOD  = 3'd1;
   localparam logic [2:0] KIND_URL     = 3'd2;
   localparam logic [2:0] KIND_PROTO   = 3'd3;
   localparam logic [2:0] KIND_VERSION = 3'd4;
   localparam logic [2:0] KIND_NAME    = 3'd5;
   localparam logic [2:0] KIND_VALUE   = 3'd6;

   localparam logic [2:0] EV_NONE       = 3'd0;
   localparam logic [2:0] EV_METHOD_END = 3'd1;
   localparam logic [2:0] EV_URL_END    = 3'd2;
   localparam logic [2:0] EV_REQ_END    = 3'd3;
   localparam logic [2:0] EV_FIELD_END  = 3'd4;
   localparam logic [2:0] EV_HEADER_END = 3'd5;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TOO_LONG = 3'd1;
   localparam logic [2:0] ERR_NO_SLASH = 3'd2;
   localparam logic [2:0] ERR_FIELDS   = 3'd3;
   localparam logic [2:0] ERR_NO_COLON = 3'd4;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_COLON = 8'd58;

   localparam logic [0:0] CSR_LINE_LIMIT  = 1'd0;
   localparam logic [0:0] CSR_FIELD_LIMIT = 1'd1;

   localparam logic [15:0] LINE_LIMIT_RESET  = 16'd8192;
   localparam logic [7:0]  FIELD_LIMIT_RESET = 8'd100;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] char_out;
      logic       tentative;
      logic       withdraw;
      logic [2:0] event_res;
      logic [2:0] error_code;
   } result_type;

endpackage

>>> rtl/core/http_request_header_tokenizer.sv
// http request header tokenizer
//
// takes one byte of a request stream per transaction on the req_ channel and
// returns one tagged result per byte on the rsp_ channel: token kind, the byte,
// tentative and withdraw marks, a token event and a sticky error code.
// req_tuser set starts a new request, clearing all parse state before that byte.
// limits are written through the csr_ port (index 0 line length limit, index 1
// field count limit) by the user only while no transaction is in flight; unchecked.
//
// the path is an input register, then the per-byte decision and the parse state
// update into the result register. one byte is accepted every cycle while the
// receiver takes results; the rate is set by the state update loop.
// when the receiver stalls, the result register holds and the input register
// fills, then req_tready drops; nothing is lost.
// reset empties both registers, clears the parse state and loads the default
// limits (8192 bytes per line, 100 field lines).
module http_request_header_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] start_new
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] char_out, [8] withdraw, [11:9] event_res,
                                    // [14:12] error_code, [15] zero
   output logic [3:0]  rsp_tuser,   // [2:0] token_kind, [3] tentative
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic [15:0] line_limit_ff;
   logic [7:0]  field_limit_ff;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   logic                 out_valid_ff;
   hrht_pkg::result_type out_ff, out_in;

   hrht_pkg::phase_type phase_ff, phase_in;
   logic        cr_ff, cr_in;
   logic        empty_ff, empty_in;
   logic [7:0]  fields_ff, fields_in;
   logic [16:0] len_ff, len_in;
   logic [2:0]  err_ff, err_in;

   hrht_pkg::phase_type cur_phase;
   logic        cur_cr;
   logic        cur_empty;
   logic [7:0]  cur_fields;
   logic [16:0] cur_len;
   logic [2:0]  cur_err;

   logic        out_free;
   logic        fire;
   logic        term;
   logic        ws;
   logic        is_cr;
   logic [16:0] len_inc;
   logic        len_over;
   logic        fields_over;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_ff.error_code, out_ff.event_res, out_ff.withdraw,
                        out_ff.char_out};
   assign rsp_tuser  = {out_ff.tentative, out_ff.token_kind};

   // parse state as seen by this byte, cleared on a new request
   always_comb begin
      if (in_start_ff) begin
         cur_phase  = hrht_pkg::PH_METHOD;
         cur_cr     = 1'b0;
         cur_empty  = 1'b1;
         cur_fields = 8'd0;
         cur_len    = 17'd0;
         cur_err    = hrht_pkg::ERR_NONE;
      end else begin
         cur_phase  = phase_ff;
         cur_cr     = cr_ff;
         cur_empty  = empty_ff;
         cur_fields = fields_ff;
         cur_len    = len_ff;
         cur_err    = err_ff;
      end
   end

   assign is_cr = (in_byte_ff == hrht_pkg::CH_CR);
   assign ws    = (in_byte_ff == hrht_pkg::CH_SPACE) ||
                  (in_byte_ff >= hrht_pkg::CH_TAB && in_byte_ff <= hrht_pkg::CH_CR);
   assign term  = (cur_phase == hrht_pkg::PH_METHOD || cur_phase == hrht_pkg::PH_URL) ?
                  (in_byte_ff == hrht_pkg::CH_SPACE) :
                  ((in_byte_ff == hrht_pkg::CH_LF) && cur_cr);
   assign len_inc     = cur_len + 17'd1;
   assign len_over    = !term && (len_inc > {1'b0, line_limit_ff});
   assign fields_over = ({1'b0, cur_fields} + 9'd1) > {1'b0, field_limit_ff};

   // next state
   always_comb begin
      phase_in  = cur_phase;
      cr_in     = cur_cr;
      empty_in  = cur_empty;
      fields_in = cur_fields;
      len_in    = cur_len;
      err_in    = cur_err;
      if (cur_err == hrht_pkg::ERR_NONE && cur_phase != hrht_pkg::PH_DONE) begin
         len_in = term ? 17'd0 : len_inc;
         if (len_over) begin
            err_in = hrht_pkg::ERR_TOO_LONG;
         end else begin
            unique case (cur_phase)
               hrht_pkg::PH_METHOD: begin
                  if (term) phase_in = hrht_pkg::PH_URL;
               end
               hrht_pkg::PH_URL: begin
                  if (term) phase_in = hrht_pkg::PH_PROTO;
               end
               hrht_pkg::PH_PROTO: begin
                  if (term) begin
                     err_in = hrht_pkg::ERR_NO_SLASH;
                  end else if (in_byte_ff == hrht_pkg::CH_SLASH) begin
                     phase_in = hrht_pkg::PH_VERSION;
                     cr_in    = 1'b0;
                  end else begin
                     cr_in = is_cr;
                  end
               end
               hrht_pkg::PH_VERSION: begin
                  if (term) begin
                     phase_in = hrht_pkg::PH_NAME;
                     cr_in    = 1'b0;
                     empty_in = 1'b1;
                  end else begin
                     cr_in = is_cr;
                  end
               end
               hrht_pkg::PH_NAME: begin
                  if (term) begin
                     cr_in = 1'b0;
                     if (cur_empty) phase_in = hrht_pkg::PH_DONE;
                     else if (fields_over) err_in = hrht_pkg::ERR_FIELDS;
                     else err_in = hrht_pkg::ERR_NO_COLON;
                  end else if (in_byte_ff == hrht_pkg::CH_COLON) begin
                     phase_in = hrht_pkg::PH_LEAD;
                     cr_in    = 1'b0;
                     empty_in = 1'b0;
                  end else if (is_cr) begin
                     if (cur_cr) empty_in = 1'b0;
                     cr_in = 1'b1;
                  end else begin
                     empty_in = 1'b0;
                     cr_in    = 1'b0;
                  end
               end
               hrht_pkg::PH_LEAD, hrht_pkg::PH_VALUE: begin
                  if (term) begin
                     if (fields_over) begin
                        err_in = hrht_pkg::ERR_FIELDS;
                     end else begin
                        fields_in = cur_fields + 8'd1;
                        phase_in  = hrht_pkg::PH_NAME;
                        empty_in  = 1'b1;
                        cr_in     = 1'b0;
                     end
                  end else begin
                     cr_in = is_cr;
                     if (cur_phase == hrht_pkg::PH_LEAD && !ws) phase_in = hrht_pkg::PH_VALUE;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // result of this byte
   always_comb begin
      out_in = '0;
      if (cur_err != hrht_pkg::ERR_NONE) begin
         out_in.error_code = cur_err;
      end else if (cur_phase == hrht_pkg::PH_DONE) begin
         out_in = '0;
      end else if (len_over) begin
         out_in.error_code = hrht_pkg::ERR_TOO_LONG;
      end else begin
         unique case (cur_phase)
            hrht_pkg::PH_METHOD: begin
               if (term) begin
                  out_in.event_res = hrht_pkg::EV_METHOD_END;
               end else begin
                  out_in.token_kind = hrht_pkg::KIND_METHOD;
                  out_in.char_out   = in_byte_ff;
               end
            end
            hrht_pkg::PH_URL: begin
               if (term) begin
                  out_in.event_res = hrht_pkg::EV_URL_END;
               end else begin
                  out_in.token_kind = hrht_pkg::KIND_URL;
                  out_in.char_out   = in_byte_ff;
               end
            end
            hrht_pkg::PH_PROTO: begin
               if (term) begin
                  out_in.error_code = hrht_pkg::ERR_NO_SLASH;
               end else if (in_byte_ff != hrht_pkg::CH_SLASH) begin
                  out_in.token_kind = hrht_pkg::KIND_PROTO;
                  out_in.char_out   = in_byte_ff;
                  out_in.tentative  = is_cr;
               end
            end
            hrht_pkg::PH_VERSION: begin
               if (term) begin
                  out_in.withdraw  = 1'b1;
                  out_in.event_res = hrht_pkg::EV_REQ_END;
               end else begin
                  out_in.token_kind = hrht_pkg::KIND_VERSION;
                  out_in.char_out   = in_byte_ff;
                  out_in.tentative  = is_cr;
               end
            end
            hrht_pkg::PH_NAME: begin
               if (term) begin
                  if (cur_empty) begin
                     out_in.withdraw  = 1'b1;
                     out_in.event_res = hrht_pkg::EV_HEADER_END;
                  end else if (fields_over) begin
                     out_in.error_code = hrht_pkg::ERR_FIELDS;
                  end else begin
                     out_in.error_code = hrht_pkg::ERR_NO_COLON;
                  end
               end else if (in_byte_ff == hrht_pkg::CH_COLON) begin
                  out_in.withdraw = 1'b1;
               end else begin
                  out_in.token_kind = hrht_pkg::KIND_NAME;
                  out_in.char_out   = in_byte_ff;
                  out_in.tentative  = ws;
               end
            end
            hrht_pkg::PH_LEAD, hrht_pkg::PH_VALUE: begin
               if (term) begin
                  if (fields_over) begin
                     out_in.error_code = hrht_pkg::ERR_FIELDS;
                  end else begin
                     out_in.withdraw  = 1'b1;
                     out_in.event_res = hrht_pkg::EV_FIELD_END;
                  end
               end else if (cur_phase == hrht_pkg::PH_VALUE) begin
                  out_in.token_kind = hrht_pkg::KIND_VALUE;
                  out_in.char_out   = in_byte_ff;
                  out_in.tentative  = is_cr;
               end else if (!ws) begin
                  out_in.token_kind = hrht_pkg::KIND_VALUE;
                  out_in.char_out   = in_byte_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_limit_ff  <= hrht_pkg::LINE_LIMIT_RESET;
         field_limit_ff <= hrht_pkg::FIELD_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            hrht_pkg::CSR_LINE_LIMIT:  line_limit_ff  <= csr_wdata;
            hrht_pkg::CSR_FIELD_LIMIT: field_limit_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= hrht_pkg::PH_METHOD;
         cr_ff        <= 1'b0;
         empty_ff     <= 1'b1;
         fields_ff    <= 8'd0;
         len_ff       <= 17'd0;
         err_ff       <= hrht_pkg::ERR_NONE;
      end else begin
         if (out_free) out_valid_ff <= in_valid_ff;
         if (fire) begin
            phase_ff  <= phase_in;
            cr_ff     <= cr_in;
            empty_ff  <= empty_in;
            fields_ff <= fields_in;
            len_ff    <= len_in;
            err_ff    <= err_in;
         end
      end
      if (fire) out_ff <= out_in;
   end

   // an error stays until a new request starts
   assert property (@(posedge clock) disable iff (reset)
      fire && !in_start_ff && err_ff != hrht_pkg::ERR_NONE |=> err_ff == $past(err_ff))
      else $error("sticky error changed without a new request");

   // error results carry no token, mark or event
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.error_code != hrht_pkg::ERR_NONE |->
      out_ff.token_kind == hrht_pkg::KIND_NONE && out_ff.event_res == hrht_pkg::EV_NONE &&
      !out_ff.withdraw && !out_ff.tentative)
      else $error("error result carries token data");

   // a tentative byte is always a tagged byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.tentative |-> out_ff.token_kind != hrht_pkg::KIND_NONE)
      else $error("tentative mark on an untagged result");

   // withdraw never comes with a tagged byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.withdraw |-> out_ff.token_kind == hrht_pkg::KIND_NONE)
      else $error("withdraw on a tagged byte");

   // a stalled result is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && out_ff == $past(out_ff))
      else $error("result register changed while stalled");

endmodule

>>> sim/http_request_header_tokenizer_test.sv
`timescale 1ns / 100ps

module http_request_header_tokenizer_test;

   localparam int CYCLE_LIMIT = 300000;
   localparam int PHASE_COUNT = 8;
   localparam int BYTES_PER_PHASE = 40;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_new;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [0:0]  req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_addr = hrht_pkg::CSR_LINE_LIMIT;
   logic [15:0] csr_wdata = 16'd0;

   byte_item_type        pending_bytes[$];
   hrht_pkg::result_type expected_tokens[$];
   byte_item_type        next_item;

   int line_limit_cfg = int'(hrht_pkg::LINE_LIMIT_RESET);
   int field_limit_cfg = int'(hrht_pkg::FIELD_LIMIT_RESET);

   hrht_pkg::phase_type tok_phase;
   logic                tok_cr_pending;
   logic                tok_line_empty;
   int                  tok_fields_seen;
   int                  tok_line_len;
   logic [2:0]          tok_error;

   int sender_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int error_count = 0;
   int bytes_sent = 0;
   int results_checked = 0;

   http_request_header_tokenizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic void clear_parse_state();
      tok_phase = hrht_pkg::PH_METHOD;
      tok_cr_pending = 1'b0;
      tok_line_empty = 1'b1;
      tok_fields_seen = 0;
      tok_line_len = 0;
      tok_error = hrht_pkg::ERR_NONE;
   endfunction

   function automatic hrht_pkg::result_type make_token(input logic [2:0] kind,
                                                       input logic [7:0] ch,
                                                       input logic tent, input logic wd,
                                                       input logic [2:0] ev,
                                                       input logic [2:0] err);
      hrht_pkg::result_type r;
      r.token_kind = kind;
      r.char_out = (kind != hrht_pkg::KIND_NONE) ? ch : 8'd0;
      r.tentative = tent;
      r.withdraw = wd;
      r.event_res = ev;
      r.error_code = err;
      return r;
   endfunction

   function automatic hrht_pkg::result_type raise_error(input logic [2:0] code);
      tok_error = code;
      return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE, code);
   endfunction

   function automatic hrht_pkg::result_type close_field();
      if (tok_fields_seen + 1 > field_limit_cfg) return raise_error(hrht_pkg::ERR_FIELDS);
      tok_fields_seen++;
      tok_phase = hrht_pkg::PH_NAME;
      tok_line_empty = 1'b1;
      tok_cr_pending = 1'b0;
      return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b1, hrht_pkg::EV_FIELD_END,
                        hrht_pkg::ERR_NONE);
   endfunction

   function automatic hrht_pkg::result_type tokenize_byte(input logic [7:0] b,
                                                          input logic start);
      logic term;
      logic blank;
      if (start) clear_parse_state();
      if (tok_error != hrht_pkg::ERR_NONE)
         return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                           tok_error);
      if (tok_phase == hrht_pkg::PH_DONE)
         return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                           hrht_pkg::ERR_NONE);
      blank = (b == hrht_pkg::CH_SPACE) || (b >= hrht_pkg::CH_TAB && b <= hrht_pkg::CH_CR);
      if (tok_phase == hrht_pkg::PH_METHOD || tok_phase == hrht_pkg::PH_URL)
         term = (b == hrht_pkg::CH_SPACE);
      else term = (b == hrht_pkg::CH_LF) && tok_cr_pending;
      if (term) begin
         tok_line_len = 0;
      end else begin
         tok_line_len++;
         if (tok_line_len > line_limit_cfg) return raise_error(hrht_pkg::ERR_TOO_LONG);
      end
      case (tok_phase)
         hrht_pkg::PH_METHOD: begin
            if (term) begin
               tok_phase = hrht_pkg::PH_URL;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0,
                                 hrht_pkg::EV_METHOD_END, hrht_pkg::ERR_NONE);
            end
            return make_token(hrht_pkg::KIND_METHOD, b, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                              hrht_pkg::ERR_NONE);
         end
         hrht_pkg::PH_URL: begin
            if (term) begin
               tok_phase = hrht_pkg::PH_PROTO;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0,
                                 hrht_pkg::EV_URL_END, hrht_pkg::ERR_NONE);
            end
            return make_token(hrht_pkg::KIND_URL, b, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                              hrht_pkg::ERR_NONE);
         end
         hrht_pkg::PH_PROTO: begin
            if (term) return raise_error(hrht_pkg::ERR_NO_SLASH);
            if (b == hrht_pkg::CH_SLASH) begin
               tok_phase = hrht_pkg::PH_VERSION;
               tok_cr_pending = 1'b0;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                                 hrht_pkg::ERR_NONE);
            end
            tok_cr_pending = (b == hrht_pkg::CH_CR);
            return make_token(hrht_pkg::KIND_PROTO, b, tok_cr_pending, 1'b0,
                              hrht_pkg::EV_NONE, hrht_pkg::ERR_NONE);
         end
         hrht_pkg::PH_VERSION: begin
            if (term) begin
               tok_phase = hrht_pkg::PH_NAME;
               tok_cr_pending = 1'b0;
               tok_line_empty = 1'b1;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b1,
                                 hrht_pkg::EV_REQ_END, hrht_pkg::ERR_NONE);
            end
            tok_cr_pending = (b == hrht_pkg::CH_CR);
            return make_token(hrht_pkg::KIND_VERSION, b, tok_cr_pending, 1'b0,
                              hrht_pkg::EV_NONE, hrht_pkg::ERR_NONE);
         end
         hrht_pkg::PH_NAME: begin
            if (term) begin
               tok_cr_pending = 1'b0;
               if (tok_line_empty) begin
                  tok_phase = hrht_pkg::PH_DONE;
                  return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b1,
                                    hrht_pkg::EV_HEADER_END, hrht_pkg::ERR_NONE);
               end
               if (tok_fields_seen + 1 > field_limit_cfg)
                  return raise_error(hrht_pkg::ERR_FIELDS);
               return raise_error(hrht_pkg::ERR_NO_COLON);
            end
            if (b == hrht_pkg::CH_COLON) begin
               tok_phase = hrht_pkg::PH_LEAD;
               tok_cr_pending = 1'b0;
               tok_line_empty = 1'b0;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b1, hrht_pkg::EV_NONE,
                                 hrht_pkg::ERR_NONE);
            end
            if (blank) begin
               if (b == hrht_pkg::CH_CR) begin
                  if (tok_cr_pending) tok_line_empty = 1'b0;
                  tok_cr_pending = 1'b1;
               end else begin
                  tok_line_empty = 1'b0;
                  tok_cr_pending = 1'b0;
               end
               return make_token(hrht_pkg::KIND_NAME, b, 1'b1, 1'b0, hrht_pkg::EV_NONE,
                                 hrht_pkg::ERR_NONE);
            end
            tok_line_empty = 1'b0;
            tok_cr_pending = 1'b0;
            return make_token(hrht_pkg::KIND_NAME, b, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                              hrht_pkg::ERR_NONE);
         end
         hrht_pkg::PH_LEAD: begin
            if (term) return close_field();
            if (b == hrht_pkg::CH_CR) begin
               tok_cr_pending = 1'b1;
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                                 hrht_pkg::ERR_NONE);
            end
            tok_cr_pending = 1'b0;
            if (blank)
               return make_token(hrht_pkg::KIND_NONE, 8'd0, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                                 hrht_pkg::ERR_NONE);
            tok_phase = hrht_pkg::PH_VALUE;
            return make_token(hrht_pkg::KIND_VALUE, b, 1'b0, 1'b0, hrht_pkg::EV_NONE,
                              hrht_pkg::ERR_NONE);
         end
         default: begin
            if (term) return close_field();
            tok_cr_pending = (b == hrht_pkg::CH_CR);
            return make_token(hrht_pkg::KIND_VALUE, b, tok_cr_pending, 1'b0,
                              hrht_pkg::EV_NONE, hrht_pkg::ERR_NONE);
         end
      endcase
   endfunction

   // byte source

   function automatic void push_byte(input logic [7:0] b, input logic start);
      byte_item_type it;
      it.data_byte = b;
      it.start_new = start;
      pending_bytes.insert(pending_bytes.size(), it);
   endfunction

   function automatic logic [7:0] pick_byte(input logic [7:0] avoid_a, input logic [7:0] avoid_b,
                                            input logic [7:0] avoid_c);
      logic [7:0] v;
      v = avoid_a;
      while (v == avoid_a || v == avoid_b || v == avoid_c) begin
         if ($urandom_range(0, 3) == 0) v = 8'($urandom_range(0, 255));
         else v = 8'($urandom_range(97, 122));
      end
      return v;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0: return hrht_pkg::CH_SPACE;
         1: return hrht_pkg::CH_TAB;
         default: return hrht_pkg::CH_CR;
      endcase
   endfunction

   function automatic void gen_request();
      int n;
      int fields;
      push_byte(pick_byte(hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE), 1'b1);
      n = $urandom_range(0, 4);
      repeat (n)
         push_byte(pick_byte(hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE), 1'b0);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      n = $urandom_range(1, 8);
      repeat (n)
         push_byte(pick_byte(hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE, hrht_pkg::CH_SPACE), 1'b0);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      n = $urandom_range(1, 4);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) push_byte(hrht_pkg::CH_CR, 1'b0);
         push_byte(pick_byte(hrht_pkg::CH_SLASH, hrht_pkg::CH_LF, hrht_pkg::CH_LF), 1'b0);
      end
      if ($urandom_range(0, 11) != 0) push_byte(hrht_pkg::CH_SLASH, 1'b0);
      n = $urandom_range(1, 4);
      repeat (n) begin
         push_byte(pick_byte(hrht_pkg::CH_CR, hrht_pkg::CH_LF, hrht_pkg::CH_LF), 1'b0);
         if ($urandom_range(0, 7) == 0) push_byte(hrht_pkg::CH_CR, 1'b0);
      end
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      fields = $urandom_range(0, 4);
      repeat (fields) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) push_byte(pick_blank(), 1'b0);
            push_byte(pick_byte(hrht_pkg::CH_COLON, hrht_pkg::CH_CR, hrht_pkg::CH_LF), 1'b0);
         end
         if ($urandom_range(0, 2) == 0) push_byte(pick_blank(), 1'b0);
         if ($urandom_range(0, 9) != 0) push_byte(hrht_pkg::CH_COLON, 1'b0);
         n = $urandom_range(0, 2);
         repeat (n) push_byte(pick_blank(), 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) begin
            push_byte(pick_byte(hrht_pkg::CH_CR, hrht_pkg::CH_LF, hrht_pkg::CH_LF), 1'b0);
            if ($urandom_range(0, 7) == 0) push_byte(hrht_pkg::CH_CR, 1'b0);
         end
         push_byte(hrht_pkg::CH_CR, 1'b0);
         push_byte(hrht_pkg::CH_LF, 1'b0);
      end
      if ($urandom_range(0, 9) == 0) push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      n = $urandom_range(0, 3);
      repeat (n) push_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   function automatic void gen_noise();
      int n;
      n = $urandom_range(1, 12);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
      repeat (n) push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
   endfunction

   function automatic void gen_directed();
      // full request with body byte
      push_byte(8'h00, 1'b1);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      push_byte("P", 1'b0);
      push_byte(hrht_pkg::CH_SLASH, 1'b0);
      push_byte("1", 1'b0);
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      push_byte("n", 1'b0);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      push_byte(hrht_pkg::CH_COLON, 1'b0);
      push_byte(hrht_pkg::CH_TAB, 1'b0);
      push_byte("v", 1'b0);
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      push_byte(8'hFF, 1'b0);
      // request line without slash, then a sticky byte
      push_byte("a", 1'b1);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      push_byte("b", 1'b0);
      push_byte(hrht_pkg::CH_SPACE, 1'b0);
      push_byte("c", 1'b0);
      push_byte(hrht_pkg::CH_CR, 1'b0);
      push_byte(hrht_pkg::CH_LF, 1'b0);
      push_byte("x", 1'b0);
   endfunction

   task automatic write_csr(input logic [0:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == hrht_pkg::CSR_LINE_LIMIT) line_limit_cfg = int'(value);
      else field_limit_cfg = int'(value[7:0]);
   endtask

   task automatic wait_drain();
      while (pending_bytes.size() != 0 || req_tvalid || expected_tokens.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_tokens.insert(expected_tokens.size(),
                                   tokenize_byte(req_tdata, req_tuser[0]));
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= next_item.data_byte;
               req_tuser <= next_item.start_new;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      hrht_pkg::result_type got;
      hrht_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.token_kind = rsp_tuser[2:0];
         got.tentative = rsp_tuser[3];
         got.char_out = rsp_tdata[7:0];
         got.withdraw = rsp_tdata[8];
         got.event_res = rsp_tdata[11:9];
         got.error_code = rsp_tdata[14:12];
         if (expected_tokens.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result transaction: tdata %h tuser %h", rsp_tdata,
                        rsp_tuser);
         end else begin
            want = expected_tokens.pop_front();
            results_checked++;
            if (got.token_kind !== want.token_kind || got.char_out !== want.char_out ||
                got.tentative !== want.tentative || got.withdraw !== want.withdraw ||
                got.event_res !== want.event_res || got.error_code !== want.error_code ||
                rsp_tdata[15] !== 1'b0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT) begin
                  $display("mismatch at result %0d: expected kind %0d char %h tent %b wd %b ev %0d err %0d",
                           results_checked, want.token_kind, want.char_out, want.tentative,
                           want.withdraw, want.event_res, want.error_code);
                  $display("   got kind %0d char %h tent %b wd %b ev %0d err %0d pad %b",
                           got.token_kind, got.char_out, got.tentative, got.withdraw,
                           got.event_res, got.error_code, rsp_tdata[15]);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      clear_parse_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: ;
            1: begin
               write_csr(hrht_pkg::CSR_LINE_LIMIT, 16'd65535);
               write_csr(hrht_pkg::CSR_FIELD_LIMIT, 16'd255);
            end
            2: begin
               write_csr(hrht_pkg::CSR_LINE_LIMIT, 16'd1);
               write_csr(hrht_pkg::CSR_FIELD_LIMIT, 16'd1);
            end
            3: begin
               write_csr(hrht_pkg::CSR_LINE_LIMIT, 16'd8);
               write_csr(hrht_pkg::CSR_FIELD_LIMIT, 16'd2);
            end
            default: begin
               write_csr(hrht_pkg::CSR_LINE_LIMIT, 16'($urandom_range(3, 20)));
               write_csr(hrht_pkg::CSR_FIELD_LIMIT, 16'($urandom_range(1, 4)));
            end
         endcase
         case (p % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 86; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 86; end
            default: begin sender_idle_pct = 31; stall_pct = 31; end
         endcase
         if (p == 0) gen_directed();
         while (pending_bytes.size() < BYTES_PER_PHASE) begin
            if ($urandom_range(0, 9) < 8) gen_request();
            else gen_noise();
         end
         wait_drain();
      end
      repeat (10) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $display("%0d expected results never arrived", expected_tokens.size());
         error_count += expected_tokens.size();
      end
      $display("sent %0d request bytes over %0d limit settings and four flow patterns",
               bytes_sent, PHASE_COUNT);
      $display("checked %0d tagged results, %0d failures", results_checked, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/hrht_pkg.sv
rtl/core/http_request_header_tokenizer.sv
sim/http_request_header_tokenizer_test.sv
